// ===== rtl/lkr_pkg.sv =====
// Shared types and constants for the LRU-K frame replacer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package lkr_pkg;

  localparam int FRAME_CNT_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int FRAME_W  = 6;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int K_W      = 4;
  localparam int HIT_W    = 4;
  localparam int STAMP_W  = 48;

  localparam logic [K_W-1:0] K_RESET = 4'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS = 2'd0,
    KIND_SET_EV = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EVICT  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_VICTIM = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_EVICT = 2'd3
  } status_t;

  // One frame table entry
  typedef struct packed {
    logic               tracked;
    logic               may_evict;
    logic [HIT_W-1:0]   hits;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch_req;
    logic clear_wr;
    logic rd_frame;
    logic rd_scan;
    logic do_update;
    logic do_evict;
    logic load_rsp;
  } lkr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic req_oor;
    logic req_evict;
  } lkr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lkr_if.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on lkr_pkg for field widths.
`default_nettype none

interface lkr_req_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::KIND_W-1:0]   kind;
  logic [lkr_pkg::FRAME_W-1:0]  frame;
  logic                         evictable;

  modport source(output valid, kind, frame, evictable, input ready);
  modport sink(input valid, kind, frame, evictable, output ready);
endinterface

interface lkr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::STATUS_W-1:0] status;
  logic [lkr_pkg::FRAME_W-1:0]  victim_frame;
  logic [lkr_pkg::TOTAL_W-1:0]  evictable_total;

  modport source(output valid, status, victim_frame, evictable_total, input ready);
  modport sink(input valid, status, victim_frame, evictable_total, output ready);
endinterface

interface lkr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::K_W-1:0]      data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkr_ctrl.sv =====
// Sequencing state machine for the LRU-K frame replacer.
// Depends on lkr_pkg; drives commands to lkr_dpath and owns the request and response handshakes.
`default_nettype none

module lkr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              rsp_ready,
  output logic                   rsp_valid,
  output lkr_pkg::lkr_cmd_t      cmd,
  input  wire lkr_pkg::lkr_sts_t sts
);
  import lkr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SCAN,
    S_TAIL,
    S_EVICT,
    S_RESP
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          if (sts.req_evict) begin
            state_next = S_SCAN;
          end else if (sts.req_oor) begin
            state_next = S_RESP;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_frame = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.do_update = 1'b1;
        state_next    = S_RESP;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_TAIL;
        end
      end
      // last scan read lands in the datapath here
      S_TAIL: begin
        state_next = S_EVICT;
      end
      S_EVICT: begin
        cmd.do_evict = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load_rsp) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lkr_dpath.sv =====
// Datapath of the LRU-K frame replacer: frame table memory, stamp counter,
// evictable count, victim scan and response registers. Depends on lkr_pkg.
`default_nettype none

module lkr_dpath #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lkr_pkg::lkr_cmd_t              cmd,
  output lkr_pkg::lkr_sts_t                   sts,
  input  wire logic [lkr_pkg::KIND_W-1:0]     req_kind,
  input  wire logic [lkr_pkg::FRAME_W-1:0]    req_frame,
  input  wire logic                           req_evictable,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lkr_pkg::K_W-1:0]        cfg_data,
  output logic [lkr_pkg::STATUS_W-1:0]        rsp_status,
  output logic [lkr_pkg::FRAME_W-1:0]         rsp_victim_frame,
  output logic [lkr_pkg::TOTAL_W-1:0]         rsp_evictable_total
);
  import lkr_pkg::*;

  localparam int IDX_W = $clog2(FRAME_CNT);
  localparam int CNT_W = $clog2(FRAME_CNT + 1);
  localparam int CMP_W = 12;

  // frame table
  entry_t mem [FRAME_CNT];
  entry_t rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic [K_W-1:0]     k_value;
  logic [K_W-1:0]     eff_k;
  kind_t              op_kind;
  logic [IDX_W-1:0]   op_idx;
  logic               op_ev;
  logic [STAMP_W-1:0] stamp_counter;
  logic [CNT_W-1:0]   ev_count;
  logic [IDX_W-1:0]   cnt;
  logic               scan_vld;
  logic [IDX_W-1:0]   scan_idx;

  logic               hist_vld, lru_vld;
  logic [IDX_W-1:0]   hist_idx, lru_idx;
  logic [STAMP_W-1:0] hist_stamp, lru_stamp;

  status_t            pend_status;
  logic [FRAME_W-1:0] pend_victim;

  // update results
  entry_t             upd_entry;
  logic               upd_wr;
  status_t            upd_status;
  logic               upd_inc, upd_dec, upd_tick;
  logic [HIT_W-1:0]   hits_new;

  // scan/evict
  logic               scan_lru, scan_take;
  logic               best_vld;
  logic [STAMP_W-1:0] best_stamp;
  logic               victim_ok;
  logic [IDX_W-1:0]   victim_idx;

  assign cfg_ready = 1'b1;
  assign eff_k     = (k_value == '0) ? K_W'(1) : k_value;

  assign sts.req_evict = (kind_t'(req_kind) == KIND_EVICT);
  assign sts.req_oor   = !sts.req_evict && (CMP_W'(req_frame) >= CMP_W'(FRAME_CNT));
  assign sts.cnt_last  = (cnt == IDX_W'(FRAME_CNT - 1));

  // Per-operation entry update on the entry read for op_idx
  always_comb begin
    upd_entry  = rd_data;
    upd_wr     = 1'b0;
    upd_status = ST_OK;
    upd_inc    = 1'b0;
    upd_dec    = 1'b0;
    upd_tick   = 1'b0;
    hits_new   = rd_data.hits;
    case (op_kind)
      KIND_ACCESS: begin
        upd_wr   = 1'b1;
        upd_tick = 1'b1;
        if (!rd_data.tracked) begin
          hits_new = HIT_W'(1);
        end else if (rd_data.hits < eff_k) begin
          hits_new = rd_data.hits + HIT_W'(1);
        end
        upd_entry.tracked   = 1'b1;
        upd_entry.may_evict = rd_data.tracked && rd_data.may_evict;
        upd_entry.hits      = hits_new;
        // stamp on first access, on reaching k, and on every access past k
        if (!rd_data.tracked || rd_data.hits >= eff_k || hits_new == HIT_W'(1) ||
            hits_new == eff_k) begin
          upd_entry.stamp = stamp_counter;
        end
      end
      KIND_SET_EV: begin
        if (rd_data.tracked) begin
          upd_wr              = 1'b1;
          upd_entry.may_evict = op_ev;
          upd_inc             = op_ev && !rd_data.may_evict;
          upd_dec             = !op_ev && rd_data.may_evict;
        end
      end
      KIND_REMOVE: begin
        if (rd_data.tracked) begin
          if (!rd_data.may_evict) begin
            upd_status = ST_NOT_EVICT;
          end else begin
            upd_wr    = 1'b1;
            upd_entry = '0;
            upd_dec   = 1'b1;
          end
        end
      end
      default: begin
        upd_wr = 1'b0;
      end
    endcase
  end

  // One scanned entry against the running best of its class; ties keep the lower frame
  always_comb begin
    scan_lru   = (rd_data.hits >= eff_k);
    best_vld   = scan_lru ? lru_vld : hist_vld;
    best_stamp = scan_lru ? lru_stamp : hist_stamp;
    scan_take  = scan_vld && rd_data.tracked && rd_data.may_evict &&
                 (!best_vld || rd_data.stamp < best_stamp);
  end

  always_comb begin
    victim_ok  = hist_vld || lru_vld;
    victim_idx = hist_vld ? hist_idx : lru_idx;
  end

  // memory ports
  always_comb begin
    rd_en   = cmd.rd_frame || cmd.rd_scan;
    rd_addr = cmd.rd_frame ? op_idx : cnt;
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.do_update && upd_wr) begin
      wr_en   = 1'b1;
      wr_addr = op_idx;
      wr_data = upd_entry;
    end else if (cmd.do_evict && victim_ok) begin
      wr_en   = 1'b1;
      wr_addr = victim_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_value       <= K_RESET;
      stamp_counter <= '0;
      ev_count      <= '0;
      cnt           <= '0;
      scan_vld      <= 1'b0;
      hist_vld      <= 1'b0;
      lru_vld       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        k_value <= cfg_data;
      end
      if (cmd.do_update && upd_tick) begin
        stamp_counter <= stamp_counter + STAMP_W'(1);
      end
      if (cmd.do_update && upd_inc) begin
        ev_count <= ev_count + CNT_W'(1);
      end else if (ev_count != '0 &&
                   ((cmd.do_update && upd_dec) || (cmd.do_evict && victim_ok))) begin
        ev_count <= ev_count - CNT_W'(1);
      end
      if (cmd.clear_wr || cmd.rd_scan) begin
        cnt <= sts.cnt_last ? '0 : cnt + IDX_W'(1);
      end
      scan_vld <= cmd.rd_scan;
      if (cmd.latch_req) begin
        hist_vld <= 1'b0;
        lru_vld  <= 1'b0;
      end else if (scan_take) begin
        if (scan_lru) begin
          lru_vld <= 1'b1;
        end else begin
          hist_vld <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.rd_scan) begin
      scan_idx <= cnt;
    end
    if (scan_take) begin
      if (scan_lru) begin
        lru_idx   <= scan_idx;
        lru_stamp <= rd_data.stamp;
      end else begin
        hist_idx   <= scan_idx;
        hist_stamp <= rd_data.stamp;
      end
    end
    if (cmd.latch_req) begin
      op_kind     <= kind_t'(req_kind);
      op_idx      <= IDX_W'(req_frame);
      op_ev       <= req_evictable;
      pend_status <= sts.req_oor ? ST_RANGE : ST_OK;
      pend_victim <= '0;
    end else if (cmd.do_update) begin
      pend_status <= upd_status;
    end else if (cmd.do_evict) begin
      pend_status <= victim_ok ? ST_OK : ST_NO_VICTIM;
      pend_victim <= victim_ok ? FRAME_W'(victim_idx) : '0;
    end
    if (cmd.load_rsp) begin
      rsp_status          <= pend_status;
      rsp_victim_frame    <= pend_victim;
      rsp_evictable_total <= TOTAL_W'(ev_count);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_k_frame_replacer.sv =====
// Top level of the LRU-K frame replacer: controller plus datapath.
// Depends on lkr_pkg, lkr_if, lkr_ctrl and lkr_dpath.
`default_nettype none

// Tracks FRAME_CNT buffer frames in a one-port-read, one-port-write table
// memory and answers one request at a time with one response. After reset
// the table is cleared one entry per cycle, during which no request is
// taken (k_value writes are accepted at any time). Record access, set
// evictability and remove go from acceptance through read and update to
// the response load; a frame out of range goes straight to the load.
// Evict walks the whole table, one entry per cycle through the memory read
// port, then decides the victim and loads the response.
// A new request is taken as soon as the previous response is loaded into
// the output register, even while that response is still waiting.
module lru_k_frame_replacer #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  lkr_req_if.sink   req,
  lkr_rsp_if.source rsp,
  lkr_cfg_if.sink   cfg
);
  import lkr_pkg::*;

  lkr_cmd_t ctl_cmd;
  lkr_sts_t dp_sts;

  lkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .cmd       (ctl_cmd),
    .sts       (dp_sts)
  );

  lkr_dpath #(
    .FRAME_CNT (FRAME_CNT)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (ctl_cmd),
    .sts                 (dp_sts),
    .req_kind            (req.kind),
    .req_frame           (req.frame),
    .req_evictable       (req.evictable),
    .cfg_valid           (cfg.valid),
    .cfg_ready           (cfg.ready),
    .cfg_data            (cfg.data),
    .rsp_status          (rsp.status),
    .rsp_victim_frame    (rsp.victim_frame),
    .rsp_evictable_total (rsp.evictable_total)
  );

`ifndef ASSERT_OFF
  // a waiting response is never overwritten
  a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_rsp |-> (!rsp.valid || rsp.ready))
    else $error("response loaded over a pending one");

  // table writes only happen while no request can be taken
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl_cmd.clear_wr || ctl_cmd.do_update || ctl_cmd.do_evict) |-> !req.ready)
    else $error("table write while accepting a request");

  // victim decision follows the end of a full scan
  a_evict_after_scan: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.do_evict |-> ($past(ctl_cmd.rd_scan, 2) && !$past(ctl_cmd.rd_scan, 1)))
    else $error("evict without a completed scan");
`endif

endmodule

`default_nettype wire
